>>> rtl/core/lswc_pkg.sv
// lswc_pkg: shared types and constants of the line segment window clipper
// no dependencies; used by the interfaces, lswc_ctrl, lswc_datapath and the top level
package lswc_pkg;

   localparam int COORD_WIDTH_DEF = 16;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_LEFT   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_RIGHT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_BOTTOM = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_TOP    = 2'd3;

   localparam int WINDOW_LEFT_RESET   = 160;
   localparam int WINDOW_RIGHT_RESET  = 1280;
   localparam int WINDOW_BOTTOM_RESET = 160;
   localparam int WINDOW_TOP_RESET    = 1280;

   // region code bits
   localparam logic [3:0] CODE_LEFT   = 4'd1;
   localparam logic [3:0] CODE_RIGHT  = 4'd2;
   localparam logic [3:0] CODE_BOTTOM = 4'd4;
   localparam logic [3:0] CODE_TOP    = 4'd8;

   localparam int MAX_PASSES = 4;
   localparam int PASS_WIDTH = 3;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_EVAL = 7'b0000010,
      ST_ABS  = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_UPD  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic absval;
      logic mul;
      logic div_step;
      logic update;
      logic out_load;
      logic out_accept;
   } dp_cmd_type;

   typedef struct packed {
      logic both_inside;
      logic share;
   } dp_status_type;

endpackage

>>> rtl/core/lswc_if.sv
// lswc_if: request, response and register write channels of the clipper
// depends on lswc_pkg
interface lswc_req_if import lswc_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lswc_rsp_if import lswc_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic signed [COORD_WIDTH-1:0] clipped_start_x;
   logic signed [COORD_WIDTH-1:0] clipped_start_y;
   logic signed [COORD_WIDTH-1:0] clipped_end_x;
   logic signed [COORD_WIDTH-1:0] clipped_end_y;

   modport source (output valid, accepted, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, input ready);
   modport sink   (input valid, accepted, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, output ready);
endinterface

interface lswc_csr_if import lswc_pkg::*; #(parameter int COORD_WIDTH = COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic [CSR_INDEX_WIDTH-1:0]    index;
   logic signed [COORD_WIDTH-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/lswc_ctrl.sv
// lswc_ctrl: sequencer of the clipper, one-hot state machine with pass and divide counters
// depends on lswc_pkg; drives lswc_datapath through dp_cmd_type
module lswc_ctrl import lswc_pkg::*; #(
   parameter int DIV_STEPS = 2 * COORD_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   localparam int CW = $clog2(DIV_STEPS);

   ctrl_state_type        state_ff, state_in;
   logic [PASS_WIDTH-1:0] pass_ff, pass_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               pass_in  = '0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.both_inside) begin
               acc_in   = 1'b1;
               state_in = ST_FIN;
            end else if (status.share || pass_ff == PASS_WIDTH'(MAX_PASSES)) begin
               acc_in   = 1'b0;
               state_in = ST_FIN;
            end else begin
               cmd.setup = 1'b1;
               state_in  = ST_ABS;
            end
         end
         ST_ABS: begin
            cmd.absval = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CW'(DIV_STEPS - 1)) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            pass_in    = pass_ff + 1'b1;
            state_in   = ST_EVAL;
         end
         ST_FIN: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load   = 1'b1;
               cmd.out_accept = acc_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= '0;
         cnt_ff       <= '0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/lswc_datapath.sv
// lswc_datapath: window registers, endpoint registers, region codes, multiplier,
// restoring divider and saturating update; depends on lswc_pkg, driven by lswc_ctrl
module lswc_datapath import lswc_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic signed [COORD_WIDTH-1:0] csr_data,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   output logic                          rsp_accepted,
   output logic signed [COORD_WIDTH-1:0] rsp_clipped_start_x,
   output logic signed [COORD_WIDTH-1:0] rsp_clipped_start_y,
   output logic signed [COORD_WIDTH-1:0] rsp_clipped_end_x,
   output logic signed [COORD_WIDTH-1:0] rsp_clipped_end_y
);

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W;
   localparam int SW = PW + 2;

   logic signed [W-1:0] win_left_ff, win_right_ff, win_bottom_ff, win_top_ff;
   logic signed [W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [W:0]   a_ff, e_ff, d_ff;
   logic signed [W:0]   a_in, e_in, d_in;
   logic signed [W-1:0] base_ff, edge_ff, base_in, edge_in;
   logic                first_ff, vert_ff, vert_in;
   logic [W-1:0]        ua_ff, ue_ff, ud_ff;
   logic                neg_ff, dzero_ff;
   logic [PW-1:0]       prod_ff;
   logic [W-1:0]        rem_ff;
   logic [3:0]          c1, c2, co;
   logic [W:0]          rem_sh, rem_sub;
   logic                ge;
   logic signed [SW-1:0] bext, qext, sum, sat_hi, sat_lo;
   logic signed [W-1:0] moved, nx, ny;

   logic                acc_out_ff;
   logic signed [W-1:0] out_sx_ff, out_sy_ff, out_ex_ff, out_ey_ff;

   function automatic logic [3:0] region(input logic signed [W-1:0] x, y, l, r, b, t);
      logic [3:0] c;
      c = '0;
      if (x < l) c = c | CODE_LEFT;
      else if (x > r) c = c | CODE_RIGHT;
      if (y < b) c = c | CODE_BOTTOM;
      else if (y > t) c = c | CODE_TOP;
      return c;
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W:0] v);
      logic [W:0] n;
      n = v[W] ? (~v + 1'b1) : v;
      return n[W-1:0];
   endfunction

   function automatic logic signed [W:0] diff(input logic signed [W-1:0] p, q);
      return {p[W-1], p} - {q[W-1], q};
   endfunction

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= W'(WINDOW_LEFT_RESET);
         win_right_ff  <= W'(WINDOW_RIGHT_RESET);
         win_bottom_ff <= W'(WINDOW_BOTTOM_RESET);
         win_top_ff    <= W'(WINDOW_TOP_RESET);
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LEFT:   win_left_ff   <= csr_data;
            CSR_WINDOW_RIGHT:  win_right_ff  <= csr_data;
            CSR_WINDOW_BOTTOM: win_bottom_ff <= csr_data;
            CSR_WINDOW_TOP:    win_top_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      c1 = region(x1_ff, y1_ff, win_left_ff, win_right_ff, win_bottom_ff, win_top_ff);
      c2 = region(x2_ff, y2_ff, win_left_ff, win_right_ff, win_bottom_ff, win_top_ff);
      status.both_inside = (c1 == 4'b0) && (c2 == 4'b0);
      status.share       = |(c1 & c2);
   end

   // pick the endpoint and edge, form the signed terms of base + a * e / d
   always_comb begin
      co = (c1 != 4'b0) ? c1 : c2;
      if ((co & CODE_TOP) != 4'b0) begin
         base_in = x1_ff;
         a_in    = diff(x2_ff, x1_ff);
         e_in    = diff(win_top_ff, y1_ff);
         d_in    = diff(y2_ff, y1_ff);
         edge_in = win_top_ff;
         vert_in = 1'b1;
      end else if ((co & CODE_BOTTOM) != 4'b0) begin
         base_in = x1_ff;
         a_in    = diff(x2_ff, x1_ff);
         e_in    = diff(win_bottom_ff, y1_ff);
         d_in    = diff(y2_ff, y1_ff);
         edge_in = win_bottom_ff;
         vert_in = 1'b1;
      end else if ((co & CODE_RIGHT) != 4'b0) begin
         base_in = y1_ff;
         a_in    = diff(y2_ff, y1_ff);
         e_in    = diff(win_right_ff, x1_ff);
         d_in    = diff(x2_ff, x1_ff);
         edge_in = win_right_ff;
         vert_in = 1'b0;
      end else begin
         base_in = y1_ff;
         a_in    = diff(y2_ff, y1_ff);
         e_in    = diff(win_left_ff, x1_ff);
         d_in    = diff(x2_ff, x1_ff);
         edge_in = win_left_ff;
         vert_in = 1'b0;
      end
   end

   // one quotient bit per step
   always_comb begin
      rem_sh  = {rem_ff, prod_ff[PW-1]};
      ge      = (rem_sh >= {1'b0, ud_ff});
      rem_sub = rem_sh - {1'b0, ud_ff};
   end

   always_comb begin
      bext   = {{(SW-W){base_ff[W-1]}}, base_ff};
      qext   = {2'b00, prod_ff};
      sum    = neg_ff ? (bext - qext) : (bext + qext);
      sat_hi = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
      sat_lo = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
      if (dzero_ff) moved = base_ff;
      else if (sum > sat_hi) moved = sat_hi[W-1:0];
      else if (sum < sat_lo) moved = sat_lo[W-1:0];
      else moved = sum[W-1:0];
      nx = vert_ff ? moved : edge_ff;
      ny = vert_ff ? edge_ff : moved;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x1_ff <= req_start_x;
         y1_ff <= req_start_y;
         x2_ff <= req_end_x;
         y2_ff <= req_end_y;
      end else if (cmd.update) begin
         if (first_ff) begin
            x1_ff <= nx;
            y1_ff <= ny;
         end else begin
            x2_ff <= nx;
            y2_ff <= ny;
         end
      end
      if (cmd.setup) begin
         a_ff     <= a_in;
         e_ff     <= e_in;
         d_ff     <= d_in;
         base_ff  <= base_in;
         edge_ff  <= edge_in;
         vert_ff  <= vert_in;
         first_ff <= (c1 != 4'b0);
      end
      if (cmd.absval) begin
         ua_ff    <= mag(a_ff);
         ue_ff    <= mag(e_ff);
         ud_ff    <= mag(d_ff);
         neg_ff   <= a_ff[W] ^ e_ff[W] ^ d_ff[W];
         dzero_ff <= (d_ff == '0);
      end
      if (cmd.mul) begin
         prod_ff <= ua_ff * ue_ff;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         prod_ff <= {prod_ff[PW-2:0], ge};
         rem_ff  <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      end
      if (cmd.out_load) begin
         acc_out_ff <= cmd.out_accept;
         out_sx_ff  <= cmd.out_accept ? x1_ff : '0;
         out_sy_ff  <= cmd.out_accept ? y1_ff : '0;
         out_ex_ff  <= cmd.out_accept ? x2_ff : '0;
         out_ey_ff  <= cmd.out_accept ? y2_ff : '0;
      end
   end

   assign rsp_accepted        = acc_out_ff;
   assign rsp_clipped_start_x = out_sx_ff;
   assign rsp_clipped_start_y = out_sy_ff;
   assign rsp_clipped_end_x   = out_ex_ff;
   assign rsp_clipped_end_y   = out_ey_ff;

endmodule

>>> rtl/core/line_segment_window_clipper.sv
// line_segment_window_clipper: Cohen-Sutherland clipping of one segment against a window
// depends on lswc_pkg, lswc_if, lswc_ctrl and lswc_datapath
//
//   channel   role  handshake          payload
//   req_chan  in    valid/ready        start_x, start_y, end_x, end_y
//   rsp_chan  out   valid/ready        accepted, clipped_start_x/_y, clipped_end_x/_y
//   csr_chan  in    valid/ready (=1)   index, data (window left/right/bottom/top)
//
// one request at a time; each request runs P = 0..4 intersection passes, each pass
// going through the states ST_EVAL, ST_ABS, ST_MUL, ST_DIV and ST_UPD
// ST_DIV runs the restoring divider, one quotient bit per cycle over a
// 2 * COORD_WIDTH bit product
// a finished response waits in the output register; a new request is taken meanwhile
// synchronous active-high reset restores the default window and empties the output
module line_segment_window_clipper import lswc_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   lswc_req_if.sink   req_chan,
   lswc_rsp_if.source rsp_chan,
   lswc_csr_if.sink   csr_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_chan.ready = 1'b1;

   lswc_ctrl #(
      .DIV_STEPS (2 * COORD_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lswc_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write           (csr_chan.valid),
      .csr_index           (csr_chan.index),
      .csr_data            (csr_chan.data),
      .req_start_x         (req_chan.start_x),
      .req_start_y         (req_chan.start_y),
      .req_end_x           (req_chan.end_x),
      .req_end_y           (req_chan.end_y),
      .rsp_accepted        (rsp_chan.accepted),
      .rsp_clipped_start_x (rsp_chan.clipped_start_x),
      .rsp_clipped_start_y (rsp_chan.clipped_start_y),
      .rsp_clipped_end_x   (rsp_chan.clipped_end_x),
      .rsp_clipped_end_y   (rsp_chan.clipped_end_y)
   );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for line_segment_window_clipper, predicts every clip in a scoreboard
// depends on lswc_pkg, lswc_if and the clipper rtl
module tb import lswc_pkg::*;;

   localparam int CW          = COORD_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 120;

   typedef struct packed {
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
   } segment_type;

   typedef struct packed {
      logic                 accepted;
      logic signed [CW-1:0] clipped_start_x;
      logic signed [CW-1:0] clipped_start_y;
      logic signed [CW-1:0] clipped_end_x;
      logic signed [CW-1:0] clipped_end_y;
   } clip_type;

   class clip_scoreboard;
      longint   win_left, win_right, win_bottom, win_top;
      clip_type expected_clips[$];
      int       errors;

      function new();
         win_left   = WINDOW_LEFT_RESET;
         win_right  = WINDOW_RIGHT_RESET;
         win_bottom = WINDOW_BOTTOM_RESET;
         win_top    = WINDOW_TOP_RESET;
         errors     = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic signed [CW-1:0] value);
         case (index)
            CSR_WINDOW_LEFT:   win_left   = longint'(value);
            CSR_WINDOW_RIGHT:  win_right  = longint'(value);
            CSR_WINDOW_BOTTOM: win_bottom = longint'(value);
            default:           win_top    = longint'(value);
         endcase
      endfunction

      function logic [3:0] region_of(longint x, longint y);
         logic [3:0] code;
         code = '0;
         if (x < win_left) code |= CODE_LEFT;
         else if (x > win_right) code |= CODE_RIGHT;
         if (y < win_bottom) code |= CODE_BOTTOM;
         else if (y > win_top) code |= CODE_TOP;
         return code;
      endfunction

      // base + a * e / d, truncated toward zero, saturated to the coordinate range
      function longint cross_edge(longint base, longint a, longint e, longint d);
         longint q, v, hi, lo;
         logic   neg;
         hi = (longint'(1) << (CW - 1)) - 1;
         lo = -hi - 1;
         if (d == 0) return base;
         q   = ((a < 0 ? -a : a) * (e < 0 ? -e : e)) / (d < 0 ? -d : d);
         neg = (a < 0) ^ (e < 0) ^ (d < 0);
         v   = neg ? base - q : base + q;
         return (v > hi) ? hi : ((v < lo) ? lo : v);
      endfunction

      function clip_type clip_segment(segment_type seg);
         longint     x1, y1, x2, y2, nx, ny;
         logic [3:0] c1, c2, co;
         logic       accept;
         clip_type   res;
         x1 = longint'(seg.start_x);
         y1 = longint'(seg.start_y);
         x2 = longint'(seg.end_x);
         y2 = longint'(seg.end_y);
         c1 = region_of(x1, y1);
         c2 = region_of(x2, y2);
         accept = 1'b0;
         for (int pass = 0; pass <= MAX_PASSES; pass++) begin
            if (c1 == 0 && c2 == 0) begin
               accept = 1'b1;
               break;
            end
            if ((c1 & c2) != 0) break;
            // out of passes: give up and reject
            if (pass == MAX_PASSES) break;
            co = (c1 != 0) ? c1 : c2;
            if ((co & CODE_TOP) != 0) begin
               nx = cross_edge(x1, x2 - x1, win_top - y1, y2 - y1);
               ny = win_top;
            end else if ((co & CODE_BOTTOM) != 0) begin
               nx = cross_edge(x1, x2 - x1, win_bottom - y1, y2 - y1);
               ny = win_bottom;
            end else if ((co & CODE_RIGHT) != 0) begin
               ny = cross_edge(y1, y2 - y1, win_right - x1, x2 - x1);
               nx = win_right;
            end else begin
               ny = cross_edge(y1, y2 - y1, win_left - x1, x2 - x1);
               nx = win_left;
            end
            if (c1 != 0) begin
               x1 = nx;
               y1 = ny;
               c1 = region_of(x1, y1);
            end else begin
               x2 = nx;
               y2 = ny;
               c2 = region_of(x2, y2);
            end
         end
         res = '0;
         if (accept) begin
            res.accepted        = 1'b1;
            res.clipped_start_x = x1[CW-1:0];
            res.clipped_start_y = y1[CW-1:0];
            res.clipped_end_x   = x2[CW-1:0];
            res.clipped_end_y   = y2[CW-1:0];
         end
         return res;
      endfunction

      function void note_request(segment_type seg);
         expected_clips.push_back(clip_segment(seg));
      endfunction

      function int pending();
         return expected_clips.size();
      endfunction

      task report(string msg);
         if (errors < 100) $display("clip check: %s", msg);
         errors++;
      endtask

      task check_result(clip_type got);
         clip_type want;
         if (expected_clips.size() == 0) begin
            report($sformatf("result with no request waiting: acc=%0b (%0d,%0d)-(%0d,%0d)",
                             got.accepted, got.clipped_start_x, got.clipped_start_y,
                             got.clipped_end_x, got.clipped_end_y));
            return;
         end
         want = expected_clips.pop_front();
         if (got !== want)
            report($sformatf("got acc=%0b (%0d,%0d)-(%0d,%0d) want acc=%0b (%0d,%0d)-(%0d,%0d)",
                             got.accepted, got.clipped_start_x, got.clipped_start_y,
                             got.clipped_end_x, got.clipped_end_y,
                             want.accepted, want.clipped_start_x, want.clipped_start_y,
                             want.clipped_end_x, want.clipped_end_y));
      endtask
   endclass

   logic           clock;
   logic           reset;
   clip_scoreboard board;
   int             cycle_count = 0;
   int             stall_mode  = 0;
   int             stall_len   = 100;
   int             stall_count = 0;

   lswc_req_if #(.COORD_WIDTH(CW)) req_chan ();
   lswc_rsp_if #(.COORD_WIDTH(CW)) rsp_chan ();
   lswc_csr_if #(.COORD_WIDTH(CW)) csr_chan ();

   line_segment_window_clipper #(.COORD_WIDTH(CW)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // response side: check every accepted result, stall on a changing pattern
   always @(posedge clock) begin
      clip_type got;
      if (!reset) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.accepted        = rsp_chan.accepted;
            got.clipped_start_x = rsp_chan.clipped_start_x;
            got.clipped_start_y = rsp_chan.clipped_start_y;
            got.clipped_end_x   = rsp_chan.clipped_end_x;
            got.clipped_end_y   = rsp_chan.clipped_end_y;
            board.check_result(got);
         end
      end
      stall_count++;
      if (stall_count >= stall_len) begin
         stall_count = 0;
         stall_mode  = $urandom_range(0, 3);
         stall_len   = $urandom_range(50, 400);
      end
      case (stall_mode)
         0:       rsp_chan.ready <= 1'b1;
         1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
         2:       rsp_chan.ready <= (stall_count % 4) != 3;
         default: rsp_chan.ready <= (stall_count % 9) == 0;
      endcase
   end

   function automatic logic signed [CW-1:0] fit_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) << (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[CW-1:0];
   endfunction

   // somewhere around the window, reaching past both edges
   function automatic logic signed [CW-1:0] near_coord(longint a, longint b);
      longint lo, hi, span;
      lo   = (a < b) ? a : b;
      hi   = (a < b) ? b : a;
      span = (hi - lo) / 2 + 32;
      lo   = longint'(fit_coord(lo - span));
      hi   = longint'(fit_coord(hi + span));
      return fit_coord(lo + longint'($urandom_range(0, int'(hi - lo))));
   endfunction

   function automatic logic signed [CW-1:0] edge_coord(longint a, longint b);
      longint v;
      case ($urandom_range(0, 6))
         0:       v = a;
         1:       v = b;
         2:       v = a - 1;
         3:       v = b + 1;
         4:       v = -(longint'(1) << (CW - 1));
         5:       v = (longint'(1) << (CW - 1)) - 1;
         default: v = 0;
      endcase
      return fit_coord(v);
   endfunction

   function automatic segment_type random_segment();
      segment_type seg;
      int          kind;
      kind = $urandom_range(0, 9);
      seg.start_x = near_coord(board.win_left, board.win_right);
      seg.start_y = near_coord(board.win_bottom, board.win_top);
      seg.end_x   = near_coord(board.win_left, board.win_right);
      seg.end_y   = near_coord(board.win_bottom, board.win_top);
      case (kind)
         5, 6: begin
            seg.start_x = CW'($urandom);
            seg.start_y = CW'($urandom);
            seg.end_x   = CW'($urandom);
            seg.end_y   = CW'($urandom);
         end
         7: begin
            if ($urandom_range(0, 1) == 0) begin
               seg.end_x = CW'($urandom);
               seg.end_y = CW'($urandom);
            end else begin
               seg.start_x = CW'($urandom);
               seg.start_y = CW'($urandom);
            end
         end
         8: begin
            seg.start_x = edge_coord(board.win_left, board.win_right);
            seg.start_y = edge_coord(board.win_bottom, board.win_top);
            seg.end_x   = edge_coord(board.win_left, board.win_right);
            seg.end_y   = edge_coord(board.win_bottom, board.win_top);
         end
         9: begin
            // horizontal or vertical line
            if ($urandom_range(0, 1) == 0) seg.end_x = seg.start_x;
            else seg.end_y = seg.start_y;
         end
         default: ;
      endcase
      return seg;
   endfunction

   function automatic segment_type mk_seg(int x1, int y1, int x2, int y2);
      segment_type seg;
      seg.start_x = CW'(x1);
      seg.start_y = CW'(y1);
      seg.end_x   = CW'(x2);
      seg.end_y   = CW'(y2);
      return seg;
   endfunction

   // request stays valid until taken; valid is lowered only by hold_off or drain
   task automatic send_request(segment_type seg);
      req_chan.valid   <= 1'b1;
      req_chan.start_x <= seg.start_x;
      req_chan.start_y <= seg.start_y;
      req_chan.end_x   <= seg.end_x;
      req_chan.end_y   <= seg.end_y;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_request(seg);
   endtask

   task automatic hold_off(int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_window(logic signed [CW-1:0] wl, logic signed [CW-1:0] wr,
                               logic signed [CW-1:0] wb, logic signed [CW-1:0] wt);
      logic [CSR_INDEX_WIDTH-1:0] idx[4];
      logic signed [CW-1:0]       val[4];
      idx = '{CSR_WINDOW_LEFT, CSR_WINDOW_RIGHT, CSR_WINDOW_BOTTOM, CSR_WINDOW_TOP};
      val = '{wl, wr, wb, wt};
      for (int i = 0; i < 4; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= idx[i];
         csr_chan.data  <= val[i];
         do @(posedge clock); while (csr_chan.ready !== 1'b1);
         board.set_register(idx[i], val[i]);
      end
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_bursts(int count);
      int sent, burst, gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_request(random_segment());
            sent++;
         end
         if ($urandom_range(0, 29) == 0) drain();
         else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) hold_off(gap);
         end
      end
   endtask

   initial begin
      segment_type          directed[$];
      logic signed [CW-1:0] wl, wr, wb, wt, tmp;
      board = new();
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.start_x <= '0;
      req_chan.start_y <= '0;
      req_chan.end_x   <= '0;
      req_chan.end_y   <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.index   <= CSR_WINDOW_LEFT;
      csr_chan.data    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // default window 160..1280 on both axes
      directed = '{
         mk_seg(320, 320, 960, 960),           // inside, accepted as is
         mk_seg(0, 320, 100, 900),             // both left, rejected
         mk_seg(300, 1400, 900, 2000),         // both above, rejected
         mk_seg(0, 640, 1600, 640),            // horizontal across left and right
         mk_seg(640, 2000, 640, 0),            // vertical across top and bottom
         mk_seg(0, 0, 1600, 1600),             // corner to corner, several passes
         mk_seg(0, 1000, 400, 2000),           // misses the corner after one clip
         mk_seg(0, 1400, 1400, 0),             // falling slope
         mk_seg(-32768, -32768, 32767, 32767),
         mk_seg(32767, -32768, -32768, 32767),
         mk_seg(640, 640, 640, 640),           // single point inside
         mk_seg(-32768, -32768, -32768, -32768),
         mk_seg(32767, 32767, 32767, 32767),
         mk_seg(160, 160, 1280, 1280),         // endpoints on the edges
         mk_seg(159, 640, 1281, 640),          // just outside both sides
         mk_seg(640, 640, 2000, 640),          // only the end is right
         mk_seg(640, 640, 640, -100),          // only the end is below
         mk_seg(640, 640, -5000, 640),         // only the end is left
         mk_seg(640, 640, 700, 30000),         // only the end is above
         mk_seg(640, 640, 0, 2000),            // end beyond the top left corner
         mk_seg(-1, -1, 0, 0),
         mk_seg(1280, 1280, 1281, 1281)
      };
      foreach (directed[i]) begin
         send_request(directed[i]);
         if ($urandom_range(0, 1) == 0) hold_off($urandom_range(1, 6));
      end
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: write_window(CW'(-160), CW'(160), CW'(-160), CW'(160));
            1: write_window(CW'(-32768), CW'(32767), CW'(-32768), CW'(32767));
            2: write_window(CW'(100), CW'(100), CW'(-50), CW'(-50));   // zero-size window
            3: write_window(CW'(1280), CW'(160), CW'(1280), CW'(160)); // inverted window
            4: write_window(CW'(32767), CW'(-32768), CW'(32767), CW'(-32768));
            5: write_window(CW'(32000), CW'(32767), CW'(-32768), CW'(-32000));
            6: write_window(CW'(WINDOW_LEFT_RESET), CW'(WINDOW_RIGHT_RESET),
                            CW'(WINDOW_BOTTOM_RESET), CW'(WINDOW_TOP_RESET));
            default: begin
               wl = CW'($urandom);
               wr = CW'($urandom);
               wb = CW'($urandom);
               wt = CW'($urandom);
               // the last phase keeps whatever order came out
               if (phase != 9 && wl > wr) begin
                  tmp = wl;
                  wl  = wr;
                  wr  = tmp;
               end
               if (phase != 9 && wb > wt) begin
                  tmp = wb;
                  wb  = wt;
                  wt  = tmp;
               end
               write_window(wl, wr, wb, wt);
            end
         endcase
         send_bursts(PHASE_ITEMS);
         drain();
      end

      repeat (160) @(posedge clock);
      if (board.errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/lswc_pkg.sv
rtl/core/lswc_if.sv
rtl/core/lswc_ctrl.sv
rtl/core/lswc_datapath.sv
rtl/core/line_segment_window_clipper.sv
tb/sv/tb.sv
